/* sv/etci_pkg.sv */
// Package for the engine torque curve interpolator: field widths and the
// speed/torque breakpoint ROM. Depends on nothing; used by engine_torque_curve_interp.
`default_nettype none

package etci_pkg;

	// Field widths
	localparam int SPEED_W  = 17;                   // signed engine speed, 1/256 rad/s
	localparam int TORQUE_W = 16;                   // unsigned torque, 1/16 N*m
	localparam int XPOS_W   = 17;                   // breakpoint speed, non-negative
	localparam int PROD_W   = XPOS_W + TORQUE_W;    // offset times torque step

	// Breakpoint ROM
	localparam int CURVE_POINTS_DEF = 17;
	localparam int TABLE_CAP        = 64;
	localparam int TIDX_W           = $clog2(TABLE_CAP);

	localparam logic [XPOS_W-1:0] CURVE_X [TABLE_CAP] = '{
		0: 17'd0,      1: 17'd16085,  2: 17'd18766,  3: 17'd21446,
		4: 17'd24127,  5: 17'd26808,  6: 17'd29489,  7: 17'd32170,
		8: 17'd34851,  9: 17'd37531, 10: 17'd40212, 11: 17'd42893,
		12: 17'd45574, 13: 17'd48255, 14: 17'd50936, 15: 17'd53616,
		16: 17'd56297,
		default: 17'd0
	};

	localparam logic [TORQUE_W-1:0] CURVE_Y [TABLE_CAP] = '{
		0: 16'd0,      1: 16'd26560,  2: 16'd30080,  3: 16'd35840,
		4: 16'd46400,  5: 16'd56800,  6: 16'd56800,  7: 16'd56800,
		8: 16'd56800,  9: 16'd56800, 10: 16'd55520, 11: 16'd52960,
		12: 16'd49920, 13: 16'd46080, 14: 16'd42560, 15: 16'd26880,
		16: 16'd0,
		default: 16'd0
	};

endpackage

`default_nettype wire

/* sv/engine_torque_curve_interp.sv */
// Engine maximum-torque curve: piecewise linear interpolation over a ROM table.
// Depends on etci_pkg (widths, breakpoint ROM).
//
//  channel  signals                                   direction
//  -------  ----------------------------------------  ---------
//  input    in_valid, in_ready, engine_speed          in
//  output   out_valid, out_ready, max_torque, in_range  out
//
// One transaction can enter every cycle while in_ready is high. Seven register stages:
// compare, segment pick, ROM lookup, multiply, quotient estimate, quotient correction, output.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall holds each full stage whose successor is full and stalled; empty
// stages keep filling, so input stays open until the whole pipe is full.
`default_nettype none

module engine_torque_curve_interp #(
	parameter int CURVE_POINTS = etci_pkg::CURVE_POINTS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [etci_pkg::SPEED_W-1:0] engine_speed,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [etci_pkg::TORQUE_W-1:0]            max_torque,
	output logic                                     in_range
);

	localparam int NSEG   = CURVE_POINTS - 1;
	localparam int SEG_W  = (NSEG > 1) ? $clog2(NSEG) : 1;
	localparam int QW     = etci_pkg::TORQUE_W;
	localparam int XW     = etci_pkg::XPOS_W;
	localparam int YW     = etci_pkg::TORQUE_W;
	localparam int PW     = etci_pkg::PROD_W;
	localparam int TW     = etci_pkg::TIDX_W;
	localparam int NST    = 7;          // s1..s6, output register
	localparam int OUTST  = NST - 1;
	localparam int RS     = XW;         // slope scale, larger than any offset
	localparam int KW     = YW + RS;    // scaled slope width
	localparam int KPW    = XW + KW;    // offset times scaled slope

	localparam logic signed [XW:0] X_FIRST = $signed({1'b0, etci_pkg::CURVE_X[0]});
	localparam logic signed [XW:0] X_LAST  =
		$signed({1'b0, etci_pkg::CURVE_X[CURVE_POINTS-1]});

	// Stage valids and per-stage advance enables
	logic [NST-1:0] vld_q;
	logic [NST-1:0] adv;

	always_comb begin
		adv[NST-1] = !vld_q[NST-1] || out_ready;
		for (int i = NST - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[OUTST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// Stage 1: compare speed against every segment in parallel
	logic signed [XW:0] spd_x;
	logic [NSEG-1:0]    seg_hit;
	logic               rng;
	logic [KW-1:0]      slope_k [NSEG];

	assign spd_x = {{(XW + 1 - etci_pkg::SPEED_W){engine_speed[etci_pkg::SPEED_W-1]}},
		engine_speed};
	assign rng = (spd_x >= X_FIRST) && (spd_x < X_LAST);

	for (genvar g = 0; g < NSEG; g++) begin : g_cmp
		localparam logic signed [XW:0] XLO = $signed({1'b0, etci_pkg::CURVE_X[g]});
		localparam logic signed [XW:0] XHI = $signed({1'b0, etci_pkg::CURVE_X[g+1]});
		// scaled torque step per speed unit, rounded down
		localparam longint DXL = (XHI > XLO) ? longint'(XHI - XLO) : longint'(1);
		localparam longint YLO = longint'(etci_pkg::CURVE_Y[g]);
		localparam longint YHI = longint'(etci_pkg::CURVE_Y[g+1]);
		localparam longint DYL = (YHI >= YLO) ? (YHI - YLO) : (YLO - YHI);
		localparam longint KL  = (DYL << RS) / DXL;
		assign seg_hit[g] = (XHI > XLO) && (spd_x >= XLO) && (spd_x < XHI);
		assign slope_k[g] = KW'(KL);
	end

	logic signed [XW:0] spd_s1;
	logic [NSEG-1:0]    seg_hit_s1;
	logic               rng_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			spd_s1     <= spd_x;
			seg_hit_s1 <= seg_hit;
			rng_s1     <= rng;
		end
	end

	// Stage 2: pick the lowest matching segment
	logic [SEG_W-1:0] seg_sel;

	always_comb begin
		seg_sel = '0;
		for (int i = NSEG - 1; i >= 0; i--) begin
			if (seg_hit_s1[i]) begin
				seg_sel = SEG_W'(i);
			end
		end
	end

	logic signed [XW:0] spd_s2;
	logic [SEG_W-1:0]   seg_s2;
	logic               hit_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			spd_s2 <= spd_s1;
			seg_s2 <= seg_sel;
			hit_s2 <= rng_s1 && (|seg_hit_s1);
		end
	end

	// Stage 3: ROM lookup, offset into segment, torque step as sign and magnitude
	logic [TW-1:0]      idx_lo;
	logic [TW-1:0]      idx_hi;
	logic [XW-1:0]      x1;
	logic [XW-1:0]      x2;
	logic [YW-1:0]      y1;
	logic [YW-1:0]      y2;
	logic signed [XW:0] off_full;

	assign idx_lo   = TW'(seg_s2);
	assign idx_hi   = idx_lo + TW'(1);
	assign x1       = etci_pkg::CURVE_X[idx_lo];
	assign x2       = etci_pkg::CURVE_X[idx_hi];
	assign y1       = etci_pkg::CURVE_Y[idx_lo];
	assign y2       = etci_pkg::CURVE_Y[idx_hi];
	assign off_full = spd_s2 - $signed({1'b0, x1});

	logic [XW-1:0] off_s3;
	logic [XW-1:0] dx_s3;
	logic [YW-1:0] y1_s3;
	logic [YW-1:0] dym_s3;
	logic [KW-1:0] k_s3;
	logic          neg_s3;
	logic          hit_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			off_s3 <= off_full[XW-1:0];
			dx_s3  <= x2 - x1;
			y1_s3  <= y1;
			neg_s3 <= (y2 < y1);
			dym_s3 <= (y2 < y1) ? (y1 - y2) : (y2 - y1);
			k_s3   <= slope_k[seg_s2];
			hit_s3 <= hit_s2;
		end
	end

	// Stage 4: exact numerator and scaled-slope product
	logic [PW-1:0]  prod_s4;
	logic [KPW-1:0] est_s4;
	logic [XW-1:0]  dx_s4;
	logic [YW-1:0]  y1_s4;
	logic           neg_s4;
	logic           hit_s4;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			prod_s4 <= PW'(off_s3) * PW'(dym_s3);
			est_s4  <= KPW'(off_s3) * KPW'(k_s3);
			dx_s4   <= dx_s3;
			y1_s4   <= y1_s3;
			neg_s4  <= neg_s3;
			hit_s4  <= hit_s3;
		end
	end

	// Stage 5: quotient estimate, exact or one short, and its product with the width
	logic [QW-1:0] qe;
	logic [QW-1:0] qe_s5;
	logic [PW-1:0] qdx_s5;
	logic [PW-1:0] prod_s5;
	logic [XW-1:0] dx_s5;
	logic [YW-1:0] y1_s5;
	logic          neg_s5;
	logic          hit_s5;

	assign qe = est_s4[RS+QW-1:RS];

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			qe_s5   <= qe;
			qdx_s5  <= PW'(qe) * PW'(dx_s4);
			prod_s5 <= prod_s4;
			dx_s5   <= dx_s4;
			y1_s5   <= y1_s4;
			neg_s5  <= neg_s4;
			hit_s5  <= hit_s4;
		end
	end

	// Stage 6: one correction step; note whether the division was exact
	logic [PW-1:0] rem0;
	logic          fix;
	logic [PW-1:0] rem1;

	assign rem0 = prod_s5 - qdx_s5;
	assign fix  = (rem0 >= PW'(dx_s5));
	assign rem1 = fix ? (rem0 - PW'(dx_s5)) : rem0;

	logic [QW-1:0] quo_s6;
	logic          rnz_s6;
	logic [YW-1:0] y1_s6;
	logic          neg_s6;
	logic          hit_s6;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			quo_s6 <= qe_s5 + QW'(fix);
			rnz_s6 <= (rem1 != '0);
			y1_s6  <= y1_s5;
			neg_s6 <= neg_s5;
			hit_s6 <= hit_s5;
		end
	end

	// Output register: floor toward minus infinity on a falling step, then clamp
	logic [QW:0]        adj;
	logic signed [QW+1:0] val;
	logic [YW-1:0]      val_sat;

	assign adj = {1'b0, quo_s6} + (QW+1)'(neg_s6 && rnz_s6);

	always_comb begin
		if (neg_s6) begin
			val = $signed({2'b00, y1_s6}) - $signed({1'b0, adj});
		end else begin
			val = $signed({2'b00, y1_s6}) + $signed({1'b0, adj});
		end
		if (val < 0) begin
			val_sat = '0;
		end else if (val[QW+1:YW] != '0) begin
			val_sat = '1;
		end else begin
			val_sat = val[YW-1:0];
		end
	end

	logic [YW-1:0] torque_q;
	logic          range_q;

	always_ff @(posedge clk) begin
		if (adv[OUTST]) begin
			torque_q <= hit_s6 ? val_sat : '0;
			range_q  <= hit_s6;
		end
	end

	assign max_torque = torque_q;
	assign in_range   = range_q;

endmodule

`default_nettype wire
